### hdl/kei_pkg.sv
// Package for the keyframe easing interpolator: table geometry, op, curve
// and status codes, and the controller state encoding. No dependencies.
package kei_pkg;
   localparam int MaxKeys = 64;
   localparam int FracBits = 16;
   localparam int IdxW = $clog2(MaxKeys);
   localparam int CntW = IdxW + 1;
   localparam int EntryW = 31 + 32 + 10;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_CLEAR  = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [2:0] CURVE_NONE   = 3'd0;
   localparam logic [2:0] CURVE_EASE   = 3'd2;
   localparam logic [2:0] CURVE_BEZIER = 3'd3;
   localparam logic [2:0] CURVE_PARAM  = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_NOKIND = 2'd3;

   localparam logic signed [31:0] FALLBACK_Q8 = -32'sd2825472;
   localparam logic [FracBits:0] FR_ONE = (FracBits+1)'(1) << FracBits;
   localparam logic [FracBits:0] FR_HALF = FR_ONE >> 1;

   // Controller states, one-hot.
   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_SCAN  = 12'b000000000010,
      S_WAIT  = 12'b000000000100,
      S_CHECK = 12'b000000001000,
      S_FETCH = 12'b000000010000,
      S_FWAIT = 12'b000000100000,
      S_DIV   = 12'b000001000000,
      S_CURVE = 12'b000010000000,
      S_MUL   = 12'b000100000000,
      S_MULW  = 12'b001000000000,
      S_FIN   = 12'b010000000000,
      S_OUT   = 12'b100000000000
   } state_type;
endpackage

### hdl/kei_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module kei_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // Registered read; a write in the same cycle returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

### hdl/keyframe_easing_interpolator.sv
// Keyframe easing interpolator top level: table RAM, scan sequencer and a
// shared divider/multiplier datapath. Depends on kei_pkg and kei_ram.
//
// Usage: each request on req_ yields one response on rsp_. For append, clear
// and the no-op the request is accepted and its response is valid in the next
// cycle. A query reads the table through the single RAM port, taking each
// entry examined through address, registered read and compare, up to 64
// entries. Interpolation adds a restoring divider that produces one quotient
// bit per cycle, a curve sequencer that uses one shared registered 18x18
// multiplier, a second division for the parametric curve, and a final 33x17
// scaling step. The block takes no new request until the response has been
// taken.
module keyframe_easing_interpolator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op[1:0], var_kind[5:2], key_time[36:6], key_value[68:37], fade_in[71:69],
   // fade_out[74:72], query_time[105:75], zero fill [111:106]
   input  logic [111:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_value[31:0], status[33:32], zero fill [39:34]
   output logic [39:0] rsp_tdata
);
   import kei_pkg::*;

   localparam int F = FracBits;

   state_type state_ff, state_in;
   logic [1:0]  op_ff;
   logic [3:0]  kind_ff;
   logic [30:0] qt_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic        have_prev_ff, have_prev_in, have_next_ff, have_next_in;
   logic [IdxW-1:0] ip_ff, ip_in, inx_ff, inx_in;
   logic [30:0] pt_ff, pt_in, nt_ff, nt_in;
   logic [31:0] pv_ff, pv_in, nv_ff, nv_in;
   logic [2:0]  fin_ff, fin_in, fout_ff, fout_in;
   logic [31:0] res_ff, res_in;
   logic [1:0]  st_ff, st_in;

   // Shared divider state.
   logic [F+31:0] dnum_ff, dnum_in;
   logic [F+32:0] drem_ff, drem_in;
   logic [F+31:0] dden_ff, dden_in;
   logic [F+31:0] dq_ff, dq_in;
   logic [6:0]    dcnt_ff, dcnt_in;

   // Curve sequencer.
   logic [F+1:0]  f_ff, f_in, t2_ff, t2_in;
   logic [3:0]    step_ff, step_in;
   logic [2*F+3:0] mp_ff;
   logic [F+1:0]  ma, mb;
   logic [F+32:0] mag_ff, mag_in;
   logic          mneg_ff, mneg_in;
   logic [32:0]   diff_abs;
   logic signed [32:0] diff_s;

   // RAM.
   logic          ram_we;
   logic [IdxW-1:0] ram_addr;
   logic [EntryW-1:0] ram_wd, ram_rd;

   kei_ram #(.Width(EntryW), .Depth(MaxKeys)) u_table (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wd), .rd_data(ram_rd)
   );

   logic [30:0] e_time;
   logic [31:0] e_val;
   logic [3:0]  e_kind;
   logic [2:0]  e_fin, e_fout;
   assign e_time = ram_rd[30:0];
   assign e_val  = ram_rd[62:31];
   assign e_kind = ram_rd[66:63];
   assign e_fin  = ram_rd[69:67];
   assign e_fout = ram_rd[72:70];

   logic req_fire, rsp_fire;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign rsp_tdata = {6'd0, st_ff, res_ff};

   logic scan_write;
   assign scan_write = req_fire && req_tdata[1:0] == OP_APPEND
      && count_ff < CntW'(MaxKeys);
   assign ram_we = scan_write;
   assign ram_wd = {req_tdata[74:72], req_tdata[71:69], req_tdata[5:2],
                    req_tdata[68:37], req_tdata[36:6]};
   always_comb begin
      if (req_fire) ram_addr = count_ff[IdxW-1:0];
      else if (state_ff == S_FETCH) ram_addr = idx_ff[IdxW-1:0];
      else ram_addr = idx_ff[IdxW-1:0];
   end

   // Shared multiplier, registered.
   always_ff @(posedge clock) begin
      mp_ff <= ma * mb;
   end

   function automatic logic [F+1:0] fround(input logic [2*F+3:0] p);
      logic [2*F+3:0] s;
      s = p + (2*F+4)'(FR_HALF);
      return s[2*F+1:F];
   endfunction

   function automatic logic [F+1:0] clamp1(input logic [F+2:0] v);
      return (v > (F+3)'(FR_ONE)) ? (F+2)'(FR_ONE) : v[F+1:0];
   endfunction

   assign diff_s = $signed({nv_ff[31], nv_ff}) - $signed({pv_ff[31], pv_ff});
   assign diff_abs = diff_s[32] ? 33'(-diff_s) : 33'(diff_s);

   // Multiplier operands chosen by curve step.
   always_comb begin
      ma = f_ff;
      mb = f_ff;
      unique case (step_ff)
         4'd1: begin ma = t2_ff; mb = (F+2)'(3*FR_ONE) - {f_ff[F:0], 1'b0}; end
         4'd4: begin ma = f_ff - (F+2)'(FR_HALF);
                     mb = (F+2)'(FR_ONE) - (f_ff - (F+2)'(FR_HALF)); end
         default: ;
      endcase
   end

   // Main sequencer.
   always_comb begin
      logic [F+32:0] trial;
      logic [F+2:0] tmp;
      logic [F+32:0] den;
      state_in = state_ff;
      count_in = count_ff; idx_in = idx_ff;
      have_prev_in = have_prev_ff; have_next_in = have_next_ff;
      ip_in = ip_ff; inx_in = inx_ff; pt_in = pt_ff; nt_in = nt_ff;
      pv_in = pv_ff; nv_in = nv_ff; fin_in = fin_ff; fout_in = fout_ff;
      res_in = res_ff; st_in = st_ff;
      dnum_in = dnum_ff; drem_in = drem_ff; dden_in = dden_ff;
      dq_in = dq_ff; dcnt_in = dcnt_ff;
      f_in = f_ff; t2_in = t2_ff; step_in = step_ff;
      mag_in = mag_ff; mneg_in = mneg_ff;
      trial = '0; tmp = '0; den = '0;
      unique case (state_ff)
         S_IDLE: if (req_fire) begin
            res_in = '0; st_in = ST_OK;
            idx_in = '0; have_prev_in = 1'b0; have_next_in = 1'b0;
            state_in = S_OUT;
            unique case (req_tdata[1:0])
               OP_APPEND: begin
                  if (scan_write) count_in = count_ff + 1'b1;
                  else st_in = ST_FULL;
               end
               OP_CLEAR: count_in = '0;
               OP_QUERY: begin
                  if (count_ff == '0) st_in = ST_EMPTY;
                  else state_in = S_SCAN;
               end
               default: ;
            endcase
         end
         S_SCAN: state_in = S_WAIT;
         S_WAIT: state_in = S_CHECK;
         S_CHECK: begin
            // ram_rd holds entry idx_ff.
            state_in = S_SCAN;
            if (e_kind == kind_ff) begin
               if (e_time < qt_ff) begin
                  have_prev_in = 1'b1; ip_in = idx_ff[IdxW-1:0];
                  pt_in = e_time; pv_in = e_val; fin_in = e_fin; fout_in = e_fout;
               end else begin
                  have_next_in = 1'b1; inx_in = idx_ff[IdxW-1:0];
                  nt_in = e_time; nv_in = e_val;
                  state_in = S_FETCH;
               end
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 >= count_ff) state_in = S_FETCH;
         end
         S_FETCH: begin
            state_in = S_OUT;
            if (!have_prev_ff) begin
               if (have_next_ff) res_in = nv_ff;
               else begin res_in = FALLBACK_Q8; st_in = ST_NOKIND; end
            end else if (!have_next_ff) res_in = pv_ff;
            else if (nt_ff == qt_ff) res_in = nv_ff;
            else if (fin_ff == CURVE_NONE) res_in = pv_ff;
            else begin
               den = (F+33)'(nt_ff - pt_ff);
               dnum_in = ((F+32)'(qt_ff - pt_ff) << F) + (F+32)'(den >> 1);
               dden_in = den[F+31:0];
               drem_in = '0; dq_in = '0; dcnt_in = 7'(F+32);
               step_in = 4'd0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // One quotient bit per cycle.
            trial = {drem_ff[F+31:0], dnum_ff[F+31]};
            dnum_in = dnum_ff << 1;
            if (trial >= {1'b0, dden_ff}) begin
               drem_in = trial - {1'b0, dden_ff}; dq_in = {dq_ff[F+30:0], 1'b1};
            end else begin
               drem_in = trial; dq_in = {dq_ff[F+30:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == 7'd1) state_in = S_CURVE;
         end
         S_CURVE: begin
            // Curve steps; divider result in dq_ff.
            state_in = S_MULW;
            unique case (step_ff)
               4'd0: begin
                  f_in = (dq_ff > (F+32)'(FR_ONE)) ? (F+2)'(FR_ONE) : dq_ff[F+1:0];
                  step_in = 4'd8;
                  state_in = S_CURVE;
               end
               4'd8: begin
                  if (f_ff <= (F+2)'(FR_HALF)) begin
                     unique case (fin_ff)
                        CURVE_EASE, CURVE_BEZIER, CURVE_PARAM: step_in = 4'd9;
                        default: begin step_in = 4'd7; state_in = S_CURVE; end
                     endcase
                  end else if (fout_ff == CURVE_EASE) step_in = 4'd4;
                  else begin step_in = 4'd5; state_in = S_CURVE; end
               end
               4'd9: begin
                  // f*f ready.
                  t2_in = fround(mp_ff);
                  if (fin_ff == CURVE_EASE) begin
                     tmp = {fround(mp_ff), 1'b0};
                     f_in = clamp1(tmp);
                     step_in = 4'd7; state_in = S_CURVE;
                  end else if (fin_ff == CURVE_BEZIER) step_in = 4'd1;
                  else begin step_in = 4'd2; state_in = S_CURVE; end
               end
               4'd1: begin
                  f_in = clamp1({1'b0, fround(mp_ff)});
                  step_in = 4'd7; state_in = S_CURVE;
               end
               4'd2: begin
                  tmp = {t2_ff, 1'b0} + (F+3)'(FR_ONE);
                  den = ((F+33)'(tmp) > (F+33)'({f_ff, 1'b0}))
                        ? (F+33)'(tmp) - (F+33)'({f_ff, 1'b0}) : (F+33)'(1);
                  dden_in = den[F+31:0];
                  dnum_in = ((F+32)'(t2_ff) << F) + (F+32)'(den >> 1);
                  drem_in = '0; dq_in = '0; dcnt_in = 7'(F+32);
                  step_in = 4'd3; state_in = S_DIV;
               end
               4'd3: begin
                  f_in = (dq_ff > (F+32)'(FR_ONE)) ? (F+2)'(FR_ONE) : dq_ff[F+1:0];
                  step_in = 4'd7; state_in = S_CURVE;
               end
               4'd4: begin
                  tmp = {fround(mp_ff), 1'b0} + (F+3)'(FR_HALF);
                  f_in = clamp1(tmp);
                  step_in = 4'd5; state_in = S_CURVE;
               end
               4'd5: begin
                  if (fin_ff == CURVE_BEZIER) step_in = 4'd9;
                  else if (fin_ff == CURVE_PARAM) step_in = 4'd9;
                  else begin step_in = 4'd7; state_in = S_CURVE; end
               end
               default: begin
                  mneg_in = diff_s[32];
                  state_in = S_MUL;
               end
            endcase
         end
         S_MULW: state_in = S_CURVE;
         S_MUL: begin
            mag_in = (F+33)'(diff_abs * f_ff[F:0]) + (F+33)'(FR_HALF);
            state_in = S_FIN;
         end
         S_FIN: begin
            if (mneg_ff) res_in = pv_ff - mag_ff[F+31:F];
            else res_in = pv_ff + mag_ff[F+31:F];
            state_in = S_OUT;
         end
         S_OUT: if (rsp_fire) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff <= req_tdata[1:0];
         kind_ff <= req_tdata[5:2];
         qt_ff <= req_tdata[105:75];
      end
      idx_ff <= idx_in; have_prev_ff <= have_prev_in; have_next_ff <= have_next_in;
      ip_ff <= ip_in; inx_ff <= inx_in; pt_ff <= pt_in; nt_ff <= nt_in;
      pv_ff <= pv_in; nv_ff <= nv_in; fin_ff <= fin_in; fout_ff <= fout_in;
      res_ff <= res_in; st_ff <= st_in;
      dnum_ff <= dnum_in; drem_ff <= drem_in; dden_ff <= dden_in;
      dq_ff <= dq_in; dcnt_ff <= dcnt_in;
      f_ff <= f_in; t2_ff <= t2_in; step_ff <= step_in;
      mag_ff <= mag_in; mneg_ff <= mneg_in;
   end

   // Checks.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxKeys)) else $error("key count overflow");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st_ff == ST_FULL |-> op_ff == OP_APPEND)
      else $error("full status on non-append");
   a_nokind_val: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st_ff == ST_NOKIND |-> res_ff == FALLBACK_Q8)
      else $error("fallback value wrong");
endmodule

### sim/tb_keyframe_easing_interpolator.sv
// Self-checking testbench for the keyframe easing interpolator: a directed
// stimulus table, then random table loads and queries checked by a predictor.
// Depends on kei_pkg and the keyframe_easing_interpolator RTL.
`timescale 1ns / 100ps

module tb_keyframe_easing_interpolator;
   import kei_pkg::*;

   localparam int NumRandom = 1200;
   localparam int WatchLimit = 20000;
   localparam logic [1:0] OP_IDLE = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  kind;
      logic [30:0] ktime;
      logic [31:0] kval;
      logic [2:0]  fin;
      logic [2:0]  fout;
      logic [30:0] qtime;
   } request_type;

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  status;
   } answer_type;

   typedef struct {
      request_type req;
      logic        has_exp;
      answer_type  exp;
   } row_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [111:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [39:0] rsp_tdata;

   // Shadow copy of the keyframe table.
   logic [30:0] tbl_time [MaxKeys];
   logic [31:0] tbl_val [MaxKeys];
   logic [3:0]  tbl_kind [MaxKeys];
   logic [2:0]  tbl_fin [MaxKeys];
   logic [2:0]  tbl_fout [MaxKeys];
   int          tbl_count;

   answer_type  expected_answers[$];
   int          mismatches;
   int          idle_cycles;
   bit          sink_done;
   row_type     directed_rows[$];

   keyframe_easing_interpolator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Fixed-point helpers for the curve arithmetic.
   function automatic logic [63:0] fr_mul(logic [63:0] a, logic [63:0] b);
      return (a * b + 64'(FR_HALF)) >> FracBits;
   endfunction

   function automatic logic [63:0] fr_clamp(logic [63:0] v);
      return (v > 64'(FR_ONE)) ? 64'(FR_ONE) : v;
   endfunction

   function automatic logic [63:0] curve_late(logic [63:0] f, logic [2:0] fin);
      logic [63:0] sq, up, dn, den;
      sq = fr_mul(f, f);
      if (fin == CURVE_BEZIER) return fr_clamp(fr_mul(sq, 3 * 64'(FR_ONE) - 2 * f));
      if (fin == CURVE_PARAM) begin
         up = 2 * sq + 64'(FR_ONE);
         dn = 2 * f;
         den = (up > dn) ? up - dn : 64'd1;
         return fr_clamp((sq * 64'(FR_ONE) + den / 2) / den);
      end
      return f;
   endfunction

   function automatic logic [63:0] ease_fraction(logic [63:0] f, logic [2:0] fin,
                                                 logic [2:0] fout);
      logic [63:0] u, g;
      if (f <= 64'(FR_HALF)) begin
         if (fin == CURVE_EASE) return fr_clamp(2 * fr_mul(f, f));
         return curve_late(f, fin);
      end
      g = f;
      if (fout == CURVE_EASE) begin
         u = f - 64'(FR_HALF);
         g = fr_clamp(2 * fr_mul(u, 64'(FR_ONE) - u) + 64'(FR_HALF));
      end
      return curve_late(g, fin);
   endfunction

   function automatic answer_type lookup_value(logic [3:0] kind, logic [30:0] qt);
      answer_type a;
      bit got_prev, got_next;
      int ip, inx;
      logic [63:0] span, passed, f, mag, d;
      longint pv, nv, diff;
      a = '0;
      got_prev = 0; got_next = 0; ip = 0; inx = 0;
      if (tbl_count == 0) begin
         a.status = ST_EMPTY;
         return a;
      end
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_kind[i] == kind) begin
            if (tbl_time[i] < qt) begin
               got_prev = 1; ip = i;
            end else begin
               got_next = 1; inx = i;
               break;
            end
         end
      end
      a.status = ST_OK;
      if (!got_prev) begin
         if (got_next) a.value = tbl_val[inx];
         else begin
            a.status = ST_NOKIND;
            a.value = FALLBACK_Q8;
         end
         return a;
      end
      if (!got_next || tbl_time[inx] == qt) begin
         a.value = got_next ? tbl_val[inx] : tbl_val[ip];
         return a;
      end
      pv = longint'($signed(tbl_val[ip]));
      nv = longint'($signed(tbl_val[inx]));
      if (tbl_fin[ip] == CURVE_NONE) begin
         a.value = pv[31:0];
         return a;
      end
      span = 64'(tbl_time[inx]) - 64'(tbl_time[ip]);
      passed = 64'(qt) - 64'(tbl_time[ip]);
      f = ((passed << FracBits) + span / 2) / span;
      f = ease_fraction(fr_clamp(f), tbl_fin[ip], tbl_fout[ip]);
      diff = nv - pv;
      mag = 64'(diff < 0 ? -diff : diff) * f;
      d = (mag + 64'(FR_HALF)) >> FracBits;
      pv = (diff < 0) ? pv - longint'(d) : pv + longint'(d);
      a.value = pv[31:0];
      return a;
   endfunction

   // Advance the shadow table and return the answer the block should give.
   function automatic answer_type apply_request(request_type r);
      answer_type a;
      a = '0;
      case (r.op)
         OP_APPEND: begin
            if (tbl_count >= MaxKeys) a.status = ST_FULL;
            else begin
               tbl_time[tbl_count] = r.ktime;
               tbl_val[tbl_count] = r.kval;
               tbl_kind[tbl_count] = r.kind;
               tbl_fin[tbl_count] = r.fin;
               tbl_fout[tbl_count] = r.fout;
               tbl_count++;
            end
         end
         OP_CLEAR: tbl_count = 0;
         OP_QUERY: a = lookup_value(r.kind, r.qtime);
         default: ;
      endcase
      return a;
   endfunction

   function automatic logic [111:0] pack_request(request_type r);
      return {6'd0, r.qtime, r.fout, r.fin, r.kval, r.ktime, r.kind, r.op};
   endfunction

   // Send one request, waiting for acceptance at the rising edge.
   task automatic send_request(request_type r, bit do_idle, bit has_exp,
                               answer_type exp);
      answer_type pred;
      while (do_idle && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      pred = apply_request(r);
      if (has_exp && pred !== exp)
         $display("note: typed answer %h differs from prediction %h", exp, pred);
      expected_answers.push_back(has_exp ? exp : pred);
      req_tdata <= pack_request(r);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic request_type rand_request(bit well_formed);
      request_type r;
      int p;
      r.op = 2'($urandom);
      r.kind = well_formed ? 4'($urandom_range(2)) : 4'($urandom);
      r.ktime = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(2000));
      r.kval = 32'($urandom);
      if ($urandom_range(3) == 0) r.kval = 32'($signed(r.kval) >>> 12);
      r.fin = 3'($urandom);
      r.fout = ($urandom_range(1) == 0) ? CURVE_EASE : 3'($urandom);
      r.qtime = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(2100));
      if (well_formed) begin
         p = $urandom_range(99);
         r.op = (p < 45) ? OP_APPEND : (p < 97) ? OP_QUERY : OP_CLEAR;
      end
      return r;
   endfunction

   function automatic row_type mk_row(logic [1:0] op, logic [3:0] kind, logic [30:0] kt,
                                      logic [31:0] kv, logic [2:0] fin, logic [2:0] fout,
                                      logic [30:0] qt, bit has_exp, answer_type exp);
      row_type w;
      w.req = '{op, kind, kt, kv, fin, fout, qt};
      w.has_exp = has_exp;
      w.exp = exp;
      return w;
   endfunction

   // Stimulus: directed table, random part with a drain pause, then the end.
   initial begin
      request_type r;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      tbl_count = 0;
      mismatches = 0;
      sink_done = 0;
      directed_rows.push_back(mk_row(OP_QUERY, 0, 0, 0, 0, 0, 5, 1, '{32'd0, ST_EMPTY}));
      directed_rows.push_back(mk_row(OP_IDLE, 0, 0, 0, 0, 0, 0, 1, '{32'd0, ST_OK}));
      directed_rows.push_back(mk_row(OP_APPEND, 0, 100, 32'h0000_0100, 1, 0, 0, 1,
                                     '{32'd0, ST_OK}));
      directed_rows.push_back(mk_row(OP_QUERY, 5, 0, 0, 0, 0, 50, 1,
                                     '{FALLBACK_Q8, ST_NOKIND}));
      directed_rows.push_back(mk_row(OP_QUERY, 0, 0, 0, 0, 0, 50, 1,
                                     '{32'h0000_0100, ST_OK}));
      directed_rows.push_back(mk_row(OP_QUERY, 0, 0, 0, 0, 0, 100, 1,
                                     '{32'h0000_0100, ST_OK}));
      directed_rows.push_back(mk_row(OP_QUERY, 0, 0, 0, 0, 0, 31'h7fff_ffff, 1,
                                     '{32'h0000_0100, ST_OK}));
      directed_rows.push_back(mk_row(OP_APPEND, 0, 300, 32'h8000_0000, 0, 0, 0, 0, '0));
      directed_rows.push_back(mk_row(OP_QUERY, 0, 0, 0, 0, 0, 200, 0, '0));
      for (int c = 0; c < 8; c++) begin
         directed_rows.push_back(mk_row(OP_APPEND, 1, 31'(c * 1000), 32'h7fff_ffff ^
                                        32'(c << 28), 3'(c), 3'(CURVE_EASE), 0, 0, '0));
         directed_rows.push_back(mk_row(OP_QUERY, 1, 0, 0, 0, 0, 31'(c * 1000 - 300),
                                        0, '0));
      end
      directed_rows.push_back(mk_row(OP_QUERY, 1, 0, 0, 0, 0, 7700, 0, '0));
      directed_rows.push_back(mk_row(OP_QUERY, 0, 0, 0, 0, 0, 101, 0, '0));
      directed_rows.push_back(mk_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 1, '{32'd0, ST_OK}));
      directed_rows.push_back(mk_row(OP_QUERY, 0, 0, 0, 0, 0, 1, 1, '{32'd0, ST_EMPTY}));
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed_rows[i])
         send_request(directed_rows[i].req, 1, directed_rows[i].has_exp,
                      directed_rows[i].exp);
      // Fill the table past its size to reach the full-table case.
      for (int i = 0; i < MaxKeys + 3; i++) begin
         r = rand_request(1);
         r.op = OP_APPEND;
         send_request(r, 1, 0, '0);
      end
      for (int i = 0; i < 6; i++) begin
         r = rand_request(1);
         r.op = OP_QUERY;
         send_request(r, 1, 0, '0);
      end
      for (int i = 0; i < NumRandom; i++) begin
         if (i == NumRandom / 2) begin
            // Hold off until every response is back.
            req_tvalid <= 1'b0;
            while (expected_answers.size() != 0) @(negedge clock);
         end
         r = rand_request($urandom_range(9) != 0);
         send_request(r, !(i > 300 && i < 450), 0, '0);
      end
      req_tvalid <= 1'b0;
      while (expected_answers.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      sink_done = 1;
   end

   // Response side: random stalls, field-by-field compare.
   initial begin
      answer_type got, exp;
      int n_rsp;
      rsp_tready = 1'b0;
      n_rsp = 0;
      forever begin
         @(negedge clock);
         rsp_tready <= (n_rsp > 20 && n_rsp < 60) ? 1'b1 : ($urandom_range(99) >= 8);
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            n_rsp++;
            got.value = rsp_tdata[31:0];
            got.status = rsp_tdata[33:32];
            if (expected_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %h", got);
            end else begin
               exp = expected_answers.pop_front();
               if (got.value !== exp.value || got.status !== exp.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: value exp %h got %h, status exp %0d got %0d",
                              exp.value, got.value, exp.status, got.status);
               end
            end
         end
      end
   end

   // Watchdog on cycles with no handshake, and the final verdict.
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || sink_done)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (sink_done) begin
            if (mismatches == 0 && expected_answers.size() == 0)
               $display("ALL CHECKS PASSED");
            else
               $display("CHECKS FAILED");
            $finish;
         end else if (idle_cycles >= WatchLimit) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end
endmodule

### files.f
hdl/kei_pkg.sv
hdl/kei_ram.sv
hdl/keyframe_easing_interpolator.sv
sim/tb_keyframe_easing_interpolator.sv
